[rtl/core/integer_alu_32bit_macros.svh]
// ----------------------------------------------------------------------------
// integer_alu_32bit_macros.svh
// Assertion macros of the integer ALU checker.
// ----------------------------------------------------------------------------
`ifndef INTEGER_ALU_32BIT_MACROS_SVH
`define INTEGER_ALU_32BIT_MACROS_SVH

// Checked only while out of reset
`define IALU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included
`define IALU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/core/ialu32_pkg.sv]
// ----------------------------------------------------------------------------
// ialu32_pkg
// Opcodes, widths, masks and bit-manipulation helpers of the 32-bit ALU.
// ----------------------------------------------------------------------------
package ialu32_pkg;

    localparam int DATA_W    = 32;
    localparam int CMD_W     = 5;
    localparam int SHAMT_W   = 5;
    localparam int S_TDATA_W = 2 * DATA_W;
    localparam int M_TDATA_W = DATA_W;

    localparam logic [DATA_W-1:0] MASK_ODD_BYTES  = 32'hFF00FF00;
    localparam logic [DATA_W-1:0] MASK_EVEN_BYTES = 32'h00FF00FF;
    localparam logic [DATA_W-1:0] ALL_ONES        = '1;

    typedef enum logic [CMD_W-1:0] {
        OP_ADD     = 5'd0,
        OP_SUB     = 5'd1,
        OP_AND     = 5'd2,
        OP_OR      = 5'd3,
        OP_XOR     = 5'd4,
        OP_SHR     = 5'd5,
        OP_SAR     = 5'd6,
        OP_ROR     = 5'd7,
        OP_SHL     = 5'd8,
        OP_SLT     = 5'd9,
        OP_SLTU    = 5'd10,
        OP_NOT     = 5'd11,
        OP_NEG     = 5'd12,
        OP_BSWAP16 = 5'd13,
        OP_BSWAP32 = 5'd14,
        OP_EXT8    = 5'd15,
        OP_EXT16   = 5'd16,
        OP_BITREV  = 5'd17,
        OP_CLZ     = 5'd18
    } alu_op_t;

    // Full byte reversal of a word
    function automatic logic [DATA_W-1:0] bswap32(input logic [DATA_W-1:0] a);
        return {a[7:0], a[15:8], a[23:16], a[31:24]};
    endfunction

    // Mirror bit order
    function automatic logic [DATA_W-1:0] bitrev32(input logic [DATA_W-1:0] a);
        logic [DATA_W-1:0] r;
        for (int i = 0; i < DATA_W; i++) begin
            r[i] = a[DATA_W-1-i];
        end
        return r;
    endfunction

    // Leading zero count by binary halving; zero input gives 32
    function automatic logic [SHAMT_W:0] clz32(input logic [DATA_W-1:0] a);
        logic [DATA_W-1:0] v;
        logic [SHAMT_W:0]  n;
        v = a;
        n = '0;
        if (v == '0) begin
            n = 6'd32;
        end else begin
            if (v[31:16] == '0) begin
                n = n + 6'd16;
                v = v << 16;
            end
            if (v[31:24] == '0) begin
                n = n + 6'd8;
                v = v << 8;
            end
            if (v[31:28] == '0) begin
                n = n + 6'd4;
                v = v << 4;
            end
            if (v[31:30] == '0) begin
                n = n + 6'd2;
                v = v << 2;
            end
            if (!v[31]) begin
                n = n + 6'd1;
            end
        end
        return n;
    endfunction

endpackage

[rtl/core/integer_alu_32bit.sv]
// ----------------------------------------------------------------------------
// integer_alu_32bit
// Stateless 32-bit integer ALU on stream channels.
// Registers from input transfer to result transfer: input reg, then result reg.
// Throughput: one item per cycle while m_tready does not stall the output; the evaluate path is combinational.
// Reset: aresetn low clears both stage valid flags; items in flight are dropped.
// ----------------------------------------------------------------------------
module integer_alu_32bit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: operand_a [31:0], operand_b [63:32]
    input  logic [ialu32_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: cmd [4:0]
    input  logic [ialu32_pkg::CMD_W-1:0]     s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // m_tdata: result [31:0]
    output logic [ialu32_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready
);
    import ialu32_pkg::*;

    logic                in_valid_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [DATA_W-1:0]   a_reg;
    logic [DATA_W-1:0]   b_reg;
    logic                out_valid_reg;
    logic [DATA_W-1:0]   result_reg;
    logic [DATA_W-1:0]   result_next;
    logic                out_ready;
    logic [SHAMT_W-1:0]  shamt;
    logic [2*DATA_W-1:0] ror_wide;

    // Pipeline flow control
    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            cmd_reg <= s_tuser;
            a_reg   <= s_tdata[DATA_W-1:0];
            b_reg   <= s_tdata[2*DATA_W-1:DATA_W];
        end
    end

    // Evaluate
    assign shamt    = b_reg[SHAMT_W-1:0];
    assign ror_wide = {a_reg, a_reg} >> shamt;

    always_comb begin
        unique case (alu_op_t'(cmd_reg))
            OP_ADD:     result_next = a_reg + b_reg;
            OP_SUB:     result_next = a_reg - b_reg;
            OP_AND:     result_next = a_reg & b_reg;
            OP_OR:      result_next = a_reg | b_reg;
            OP_XOR:     result_next = a_reg ^ b_reg;
            OP_SHR:     result_next = a_reg >> shamt;
            OP_SAR:     result_next = $unsigned($signed(a_reg) >>> shamt);
            OP_ROR:     result_next = ror_wide[DATA_W-1:0];
            OP_SHL:     result_next = a_reg << shamt;
            OP_SLT:     result_next = {31'd0, $signed(a_reg) < $signed(b_reg)};
            OP_SLTU:    result_next = {31'd0, a_reg < b_reg};
            OP_NOT:     result_next = ~a_reg;
            OP_NEG:     result_next = '0 - a_reg;
            OP_BSWAP16: result_next = ((a_reg & MASK_ODD_BYTES) >> 8)
                                    | ((a_reg & MASK_EVEN_BYTES) << 8);
            OP_BSWAP32: result_next = bswap32(a_reg);
            OP_EXT8:    result_next = {{24{a_reg[7]}}, a_reg[7:0]};
            OP_EXT16:   result_next = {{16{a_reg[15]}}, a_reg[15:0]};
            OP_BITREV:  result_next = bitrev32(a_reg);
            OP_CLZ:     result_next = {26'd0, clz32(a_reg)};
            default:    result_next = ALL_ONES;
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
        if (out_ready && in_valid_reg) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

endmodule

[rtl/core/ialu32_checker.sv]
// ----------------------------------------------------------------------------
// ialu32_checker
// Port-level checks of the 32-bit ALU, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_alu_32bit_macros.svh"

module ialu32_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [ialu32_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready
);
    logic [1:0] occ_reg;
    logic [1:0] occ_next;
    logic       s_xfer;
    logic       m_xfer;
    logic       m_stall;
    logic       occ_ok;

    assign s_xfer  = s_tvalid && s_tready;
    assign m_xfer  = m_tvalid && m_tready;
    assign m_stall = m_tvalid && !m_tready;
    assign occ_ok  = (occ_reg != 2'd0) && (occ_reg != 2'd3);

    // Items inside the block
    always_comb begin
        occ_next = occ_reg;
        if (s_xfer && !m_xfer) begin
            occ_next = occ_reg + 2'd1;
        end else if (m_xfer && !s_xfer) begin
            occ_next = occ_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 2'd0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    `IALU_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid, "result valid after reset")
    `IALU_ASSERT(a_stall_holds, m_stall |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `IALU_ASSERT(a_idle_ready, !m_tvalid |-> s_tready, "input stalled with empty output")
    `IALU_ASSERT(a_no_phantom, m_tvalid |-> occ_ok, "result without a pending item")

endmodule

bind integer_alu_32bit ialu32_checker u_ialu32_checker (.*);
